/* design/serial_frame_responder_top_macros.svh */
// assertion macros for the serial frame responder
// used by serial_frame_responder_top.sv, no other dependencies
`ifndef SERIAL_FRAME_RESPONDER_TOP_MACROS_SVH
`define SERIAL_FRAME_RESPONDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");
// next-cycle implication
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");
`else
`define SFR_ASSERT_NOW(label, clk, rst, ante, cons)
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* design/sfr_pkg.sv */
// shared types and constants for the serial frame responder
// no dependencies
`default_nettype none

package sfr_pkg;

   // event kinds on the request channel
   typedef enum logic [1:0] {
      EV_RX_BYTE = 2'd0,
      EV_OVERRUN = 2'd1,
      EV_TX_DONE = 2'd2
   } event_mode_type;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ACCEPT_MIN = 1'b0,
      CSR_HYST_GAP   = 1'b1
   } csr_index_type;

   // frame and reply geometry
   localparam logic [2:0] FRAME_DATA = 3'd4;
   localparam logic [2:0] REPLY_LEN  = 3'd5;
   // data bytes that are kept (the last one only feeds the sum)
   localparam logic [2:0] KEPT_BYTES = 3'd3;

   // configuration reset values
   localparam logic [7:0] ACCEPT_MIN_RESET = 8'd30;
   localparam logic [6:0] HYST_GAP_RESET   = 7'd3;

endpackage

`default_nettype wire

/* design/serial_frame_responder_top.sv */
// channel  | ports                                          | direction
// req      | req_valid/req_ready, mode rx_byte temperature  | in
//          |   ctrl_state                                   |
// rsp      | rsp_valid/rsp_ready, tx and frame status,      | out
//          |   stored limits, receive_enabled               |
// csr      | csr_valid/csr_ready, csr_index csr_data        | in
//
// one event per cycle while the response is taken; each transfer gives one registered response in the next cycle
// the response register frees in the cycle it is taken, so events stream
// back to back; a stalled response holds off the request side only
// csr writes are taken every cycle
// reset is synchronous and clears counters, limits and the response slot
// depends on sfr_pkg and serial_frame_responder_top_macros.svh
`default_nettype none
`include "serial_frame_responder_top_macros.svh"

module serial_frame_responder_top
   import sfr_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [7:0]                  req_rx_byte,
   input  wire logic signed [7:0]           req_temperature,
   input  wire logic [7:0]                  req_ctrl_state,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_tx_valid,
   output logic [7:0]                       rsp_tx_byte,
   output logic                             rsp_frame_accepted,
   output logic                             rsp_checksum_error,
   output logic signed [7:0]                rsp_ac_limit,
   output logic [7:0]                       rsp_mode_byte,
   output logic signed [7:0]                rsp_dc_high_limit,
   output logic signed [7:0]                rsp_dc_low_limit,
   output logic                             rsp_receive_enabled,
   // configuration channel
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [7:0]                  csr_data
);

   // configuration
   logic [7:0] accept_min_ff;
   logic [6:0] hyst_gap_ff;

   // receive side
   logic [7:0] rx_data_ff [0:2];
   logic [7:0] rx_data_in;
   logic       rx_data_we;
   logic [2:0] rx_count_ff, rx_count_in;
   logic [7:0] rx_sum_ff, rx_sum_in;

   // transmit side, reply bytes one to four (byte zero goes out at once)
   logic [7:0] tx_buf_ff [1:4];
   logic [7:0] tx_buf_in [1:4];
   logic       tx_buf_we;
   logic [2:0] tx_offset_ff, tx_offset_in;
   logic       tx_active_ff, tx_active_in;

   // stored limits
   logic [7:0] ac_limit_ff, ac_limit_in;
   logic [7:0] mode_ff, mode_in;
   logic [7:0] dc_high_ff, dc_high_in;
   logic [7:0] dc_low_ff, dc_low_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       tx_valid_ff, tx_valid_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic       frame_ok_ff, frame_ok_in;
   logic       cksum_err_ff, cksum_err_in;

   logic       req_xfer;
   logic       ac_pass, dc_pass;
   logic [7:0] reply_sum;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // limit checks against the signed minimum
   assign ac_pass = $signed(rx_data_ff[0]) >= $signed(accept_min_ff);
   assign dc_pass = $signed(rx_data_ff[1]) >= $signed(accept_min_ff);

   // event decode and next state
   always_comb begin
      rx_data_in   = req_rx_byte;
      rx_data_we   = 1'b0;
      rx_count_in  = rx_count_ff;
      rx_sum_in    = rx_sum_ff;
      tx_offset_in = tx_offset_ff;
      tx_active_in = tx_active_ff;
      tx_buf_we    = 1'b0;
      ac_limit_in  = ac_limit_ff;
      mode_in      = mode_ff;
      dc_high_in   = dc_high_ff;
      dc_low_in    = dc_low_ff;
      tx_valid_in  = 1'b0;
      tx_byte_in   = 8'd0;
      frame_ok_in  = 1'b0;
      cksum_err_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (ac_pass) begin
         ac_limit_in = rx_data_ff[0];
         mode_in     = rx_data_ff[2];
      end
      if (dc_pass) begin
         dc_high_in = rx_data_ff[1];
         dc_low_in  = rx_data_ff[1] - {1'b0, hyst_gap_ff};
      end
      tx_buf_in[1] = dc_high_in;
      tx_buf_in[2] = req_ctrl_state;
      tx_buf_in[3] = req_temperature;
      reply_sum    = ~req_temperature + dc_high_in + req_ctrl_state + req_temperature;
      tx_buf_in[4] = ~reply_sum;

      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         case (req_mode)
            EV_RX_BYTE: begin
               if (!tx_active_ff) begin
                  if (rx_count_ff < FRAME_DATA) begin
                     rx_data_we  = rx_count_ff < KEPT_BYTES;
                     rx_sum_in   = rx_sum_ff + req_rx_byte;
                     rx_count_in = rx_count_ff + 3'd1;
                     ac_limit_in = ac_limit_ff;
                     mode_in     = mode_ff;
                     dc_high_in  = dc_high_ff;
                     dc_low_in   = dc_low_ff;
                  end else begin
                     rx_count_in = 3'd0;
                     rx_sum_in   = 8'd0;
                     if (~rx_sum_ff != req_rx_byte) begin
                        cksum_err_in = 1'b1;
                        ac_limit_in  = ac_limit_ff;
                        mode_in      = mode_ff;
                        dc_high_in   = dc_high_ff;
                        dc_low_in    = dc_low_ff;
                     end else begin
                        frame_ok_in  = 1'b1;
                        tx_buf_we    = 1'b1;
                        tx_offset_in = 3'd1;
                        tx_active_in = 1'b1;
                        tx_valid_in  = 1'b1;
                        tx_byte_in   = ~req_temperature;
                     end
                  end
               end else begin
                  ac_limit_in = ac_limit_ff;
                  mode_in     = mode_ff;
                  dc_high_in  = dc_high_ff;
                  dc_low_in   = dc_low_ff;
               end
            end
            EV_TX_DONE: begin
               if (tx_active_ff) begin
                  if (tx_offset_ff >= REPLY_LEN) begin
                     tx_active_in = 1'b0;
                  end else begin
                     tx_valid_in  = 1'b1;
                     tx_byte_in   = tx_buf_ff[tx_offset_ff];
                     tx_offset_in = tx_offset_ff + 3'd1;
                  end
               end
               ac_limit_in = ac_limit_ff;
               mode_in     = mode_ff;
               dc_high_in  = dc_high_ff;
               dc_low_in   = dc_low_ff;
            end
            default: begin
               // overrun and unused codes leave the stored state alone
               ac_limit_in = ac_limit_ff;
               mode_in     = mode_ff;
               dc_high_in  = dc_high_ff;
               dc_low_in   = dc_low_ff;
            end
         endcase
      end else begin
         ac_limit_in = ac_limit_ff;
         mode_in     = mode_ff;
         dc_high_in  = dc_high_ff;
         dc_low_in   = dc_low_ff;
      end
   end

   // control state and limits
   always_ff @(posedge clock) begin
      if (reset) begin
         accept_min_ff <= ACCEPT_MIN_RESET;
         hyst_gap_ff   <= HYST_GAP_RESET;
         rx_count_ff   <= 3'd0;
         rx_sum_ff     <= 8'd0;
         tx_offset_ff  <= 3'd0;
         tx_active_ff  <= 1'b0;
         ac_limit_ff   <= 8'd0;
         mode_ff       <= 8'd0;
         dc_high_ff    <= 8'd0;
         dc_low_ff     <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCEPT_MIN: accept_min_ff <= csr_data;
               CSR_HYST_GAP:   hyst_gap_ff   <= csr_data[6:0];
               default: ;
            endcase
         end
         rx_count_ff  <= rx_count_in;
         rx_sum_ff    <= rx_sum_in;
         tx_offset_ff <= tx_offset_in;
         tx_active_ff <= tx_active_in;
         ac_limit_ff  <= ac_limit_in;
         mode_ff      <= mode_in;
         dc_high_ff   <= dc_high_in;
         dc_low_ff    <= dc_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rx_data_we) begin
         rx_data_ff[rx_count_ff[1:0]] <= rx_data_in;
      end
      if (tx_buf_we) begin
         tx_buf_ff <= tx_buf_in;
      end
      if (req_xfer) begin
         tx_valid_ff  <= tx_valid_in;
         tx_byte_ff   <= tx_byte_in;
         frame_ok_ff  <= frame_ok_in;
         cksum_err_ff <= cksum_err_in;
      end
   end

   // response outputs; stored state only changes on a request transfer
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tx_valid        = tx_valid_ff;
   assign rsp_tx_byte         = tx_byte_ff;
   assign rsp_frame_accepted  = frame_ok_ff;
   assign rsp_checksum_error  = cksum_err_ff;
   assign rsp_ac_limit        = ac_limit_ff;
   assign rsp_mode_byte       = mode_ff;
   assign rsp_dc_high_limit   = dc_high_ff;
   assign rsp_dc_low_limit    = dc_low_ff;
   assign rsp_receive_enabled = !tx_active_ff;

   // checks
   `SFR_ASSERT_NOW(a_frame_flags_exclusive, clock, reset,
      rsp_valid_ff, !(frame_ok_ff && cksum_err_ff))
   `SFR_ASSERT_NOW(a_frame_starts_reply, clock, reset,
      rsp_valid_ff && frame_ok_ff, tx_valid_ff && tx_active_ff)
   `SFR_ASSERT_NOW(a_rx_count_range, clock, reset, 1'b1, rx_count_ff <= FRAME_DATA)
   `SFR_ASSERT_NOW(a_tx_offset_range, clock, reset, 1'b1, tx_offset_ff <= REPLY_LEN)
   `SFR_ASSERT_NOW(a_idle_rx_while_tx, clock, reset,
      tx_active_ff, rx_count_ff == 3'd0 && rx_sum_ff == 8'd0)
   `SFR_ASSERT_NEXT(a_stall_holds_state, clock, reset,
      rsp_valid_ff && !rsp_ready, $stable(tx_active_ff) && $stable(rx_count_ff))

endmodule

`default_nettype wire
